### rtl/core/rie_pkg.sv
`timescale 1ns / 1ps

package rie_pkg;

    localparam int WORD_W   = 32;
    localparam int REG_W    = 5;
    localparam int IMM_W    = 16;
    localparam int CNT_W    = 16;
    localparam int NUM_REGS = 32;
    localparam int IN_W     = 112;
    localparam int OUT_W    = 88;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;
    localparam logic [WORD_W-1:0] PC_STEP  = 32'd4;
    localparam logic [REG_W-1:0]  REG_ZERO = 5'd0;

    // operation codes
    typedef enum logic [4:0] {
        OP_SLL   = 5'd0,
        OP_SRL   = 5'd1,
        OP_SRA   = 5'd2,
        OP_SLLV  = 5'd3,
        OP_SRLV  = 5'd4,
        OP_SRAV  = 5'd5,
        OP_MFHI  = 5'd6,
        OP_MTHI  = 5'd7,
        OP_MFLO  = 5'd8,
        OP_MTLO  = 5'd9,
        OP_ADDU  = 5'd10,
        OP_SUBU  = 5'd11,
        OP_AND   = 5'd12,
        OP_OR    = 5'd13,
        OP_XOR   = 5'd14,
        OP_NOR   = 5'd15,
        OP_SLT   = 5'd16,
        OP_SLTU  = 5'd17,
        OP_ADDIU = 5'd18,
        OP_ANDI  = 5'd19,
        OP_ORI   = 5'd20,
        OP_XORI  = 5'd21,
        OP_LUI   = 5'd22,
        OP_SLTI  = 5'd23,
        OP_SLTIU = 5'd24
    } op_t;

    // which bank holds the latest value of a register
    typedef enum logic [1:0] {
        LOC_ZERO   = 2'd0,
        LOC_LOAD   = 2'd1,
        LOC_RESULT = 2'd2
    } loc_t;

    // input word, last field (func) in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0] entry_address;
        logic              block_start;
        logic [WORD_W-1:0] load_value;
        logic [REG_W-1:0]  load_reg;
        logic              load_valid;
        logic [IMM_W-1:0]  imm_value;
        logic [REG_W-1:0]  shift_amount;
        logic [REG_W-1:0]  dst_index;
        logic [REG_W-1:0]  tgt_index;
        logic [REG_W-1:0]  src_index;
        logic [4:0]        func;
    } in_item_t;

    // output word, padded to whole bytes
    typedef struct packed {
        logic [1:0]        pad;
        logic [CNT_W-1:0]  retired_count;
        logic [WORD_W-1:0] next_address;
        logic [WORD_W-1:0] wb_value;
        logic [REG_W-1:0]  wb_reg;
        logic              wb_valid;
    } out_item_t;

    // alu outcome for one word
    typedef struct packed {
        logic              ok;
        logic              wr;
        logic [REG_W-1:0]  dst;
        logic [WORD_W-1:0] val;
        logic              hi_we;
        logic              lo_we;
    } alu_res_t;

    // register file write request at commit
    typedef struct packed {
        logic              ld_en;
        logic [REG_W-1:0]  ld_reg;
        logic [WORD_W-1:0] ld_val;
        logic              wr_en;
        logic [REG_W-1:0]  wr_reg;
        logic [WORD_W-1:0] wr_val;
    } rf_wr_t;

endpackage

### rtl/core/rie_alu.sv
`timescale 1ns / 1ps

module rie_alu (
    input  logic [4:0]                   func,
    input  logic [rie_pkg::WORD_W-1:0]   rs,
    input  logic [rie_pkg::WORD_W-1:0]   rt,
    input  logic [rie_pkg::REG_W-1:0]    shift_amount,
    input  logic [rie_pkg::IMM_W-1:0]    imm_value,
    input  logic [rie_pkg::REG_W-1:0]    dst_index,
    input  logic [rie_pkg::REG_W-1:0]    tgt_index,
    input  logic [rie_pkg::WORD_W-1:0]   hi,
    input  logic [rie_pkg::WORD_W-1:0]   lo,
    output rie_pkg::alu_res_t            res
);
    import rie_pkg::*;

    logic [WORD_W-1:0] imm_sext;
    logic [WORD_W-1:0] imm_zext;
    logic [REG_W-1:0]  var_sa;
    logic [WORD_W-1:0] val;
    logic [REG_W-1:0]  dst;
    logic              ok;
    logic              wr;
    logic              hi_we;
    logic              lo_we;

    assign imm_sext = {{(WORD_W-IMM_W){imm_value[IMM_W-1]}}, imm_value};
    assign imm_zext = {{(WORD_W-IMM_W){1'b0}}, imm_value};
    assign var_sa   = rs[REG_W-1:0];

    // operation decode
    always_comb
    begin
        val   = '0;
        dst   = REG_ZERO;
        ok    = 1'b1;
        wr    = 1'b1;
        hi_we = 1'b0;
        lo_we = 1'b0;
        unique case (op_t'(func))
            OP_SLL:   begin dst = dst_index; val = rt << shift_amount; end
            OP_SRL:   begin dst = dst_index; val = rt >> shift_amount; end
            OP_SRA:   begin dst = dst_index; val = $unsigned($signed(rt) >>> shift_amount); end
            OP_SLLV:  begin dst = dst_index; val = rt << var_sa; end
            OP_SRLV:  begin dst = dst_index; val = rt >> var_sa; end
            OP_SRAV:  begin dst = dst_index; val = $unsigned($signed(rt) >>> var_sa); end
            OP_MFHI:  begin dst = dst_index; val = hi; end
            OP_MTHI:  begin wr = 1'b0; hi_we = 1'b1; end
            OP_MFLO:  begin dst = dst_index; val = lo; end
            OP_MTLO:  begin wr = 1'b0; lo_we = 1'b1; end
            OP_ADDU:  begin dst = dst_index; val = rs + rt; end
            OP_SUBU:  begin dst = dst_index; val = rs - rt; end
            OP_AND:   begin dst = dst_index; val = rs & rt; end
            OP_OR:    begin dst = dst_index; val = rs | rt; end
            OP_XOR:   begin dst = dst_index; val = rs ^ rt; end
            OP_NOR:   begin dst = dst_index; val = ~(rs | rt); end
            OP_SLT:   begin dst = dst_index; val = {31'd0, $signed(rs) < $signed(rt)}; end
            OP_SLTU:  begin dst = dst_index; val = {31'd0, rs < rt}; end
            OP_ADDIU: begin dst = tgt_index; val = rs + imm_sext; end
            OP_ANDI:  begin dst = tgt_index; val = rs & imm_zext; end
            OP_ORI:   begin dst = tgt_index; val = rs | imm_zext; end
            OP_XORI:  begin dst = tgt_index; val = rs ^ imm_zext; end
            OP_LUI:   begin dst = tgt_index; val = {imm_value, {(WORD_W-IMM_W){1'b0}}}; end
            OP_SLTI:  begin dst = tgt_index; val = {31'd0, $signed(rs) < $signed(imm_sext)}; end
            OP_SLTIU: begin dst = tgt_index; val = {31'd0, rs < imm_sext}; end
            default:  begin ok = 1'b0; wr = 1'b0; end
        endcase
    end

    // writes to register zero are dropped and reported as no write
    always_comb
    begin
        res.ok    = ok;
        res.hi_we = hi_we;
        res.lo_we = lo_we;
        res.wr    = wr && (dst != REG_ZERO);
        res.dst   = res.wr ? dst : REG_ZERO;
        res.val   = res.wr ? val : '0;
    end

endmodule

### rtl/core/rie_regfile.sv
`timescale 1ns / 1ps

module rie_regfile (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [rie_pkg::REG_W-1:0]    rs_addr,
    input  logic [rie_pkg::REG_W-1:0]    rt_addr,
    output logic [rie_pkg::WORD_W-1:0]   rs_data,
    output logic [rie_pkg::WORD_W-1:0]   rt_data,
    input  rie_pkg::rf_wr_t              wr
);
    import rie_pkg::*;

    // load bank and result bank, one write port each
    logic [WORD_W-1:0] load_mem   [NUM_REGS];
    logic [WORD_W-1:0] result_mem [NUM_REGS];
    loc_t              loc_reg    [NUM_REGS];

    logic [WORD_W-1:0] ld_rs_reg;
    logic [WORD_W-1:0] ld_rt_reg;
    logic [WORD_W-1:0] res_rs_reg;
    logic [WORD_W-1:0] res_rt_reg;
    loc_t              loc_rs_reg;
    loc_t              loc_rt_reg;

    // load bank
    always_ff @(posedge clk)
    begin
        if (wr.ld_en)
        begin
            load_mem[wr.ld_reg] <= wr.ld_val;
        end
        if (rd_en)
        begin
            ld_rs_reg <= load_mem[rs_addr];
            ld_rt_reg <= load_mem[rt_addr];
        end
    end

    // result bank
    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            result_mem[wr.wr_reg] <= wr.wr_val;
        end
        if (rd_en)
        begin
            res_rs_reg <= result_mem[rs_addr];
            res_rt_reg <= result_mem[rt_addr];
        end
    end

    // per-register bank marks, cleared by reset so unwritten registers read zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                loc_reg[i] <= LOC_ZERO;
            end
            loc_rs_reg <= LOC_ZERO;
            loc_rt_reg <= LOC_ZERO;
        end
        else
        begin
            if (wr.ld_en)
            begin
                loc_reg[wr.ld_reg] <= LOC_LOAD;
            end
            if (wr.wr_en)
            begin
                loc_reg[wr.wr_reg] <= LOC_RESULT;
            end
            if (rd_en)
            begin
                loc_rs_reg <= loc_reg[rs_addr];
                loc_rt_reg <= loc_reg[rt_addr];
            end
        end
    end

    // pick the bank holding the latest value
    always_comb
    begin
        case (loc_rs_reg)
            LOC_LOAD:   rs_data = ld_rs_reg;
            LOC_RESULT: rs_data = res_rs_reg;
            default:    rs_data = '0;
        endcase
        case (loc_rt_reg)
            LOC_LOAD:   rt_data = ld_rt_reg;
            LOC_RESULT: rt_data = res_rt_reg;
            default:    rt_data = '0;
        endcase
    end

endmodule

### rtl/core/risc_integer_alu_execute.sv
`timescale 1ns / 1ps

// Integer execute stage: one decoded instruction per input word.
// Input channel s_*: s_tdata carries the decoded instruction, the pending
// delayed load and the block start request. Output channel m_*: m_tdata
// carries the register write, the next program counter and the retired
// count; m_tuser flags an unsupported operation.
// Operands are read at the edge that accepts a word, and the execute stage
// then writes its result into the output register once that register is free,
// which raises m_tvalid.
// Throughput: one word per cycle while m_tready is high. The register file
// sits in two banks with registered reads; a result of the word just ahead
// is forwarded, so back-to-back dependent instructions run at full rate.
// Reset: register file, hi, lo, program counter and retired count read zero;
// both stages are empty and s_tready is high.
// Stall: when m_tready is low the output word holds, the execute stage holds
// its word and s_tready drops once both stages are full; nothing is lost.
module risc_integer_alu_execute (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // func, src_index, tgt_index, dst_index, shift_amount, imm_value,
    // load_valid, load_reg, load_value, block_start, entry_address
    input  logic [rie_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // wb_valid, wb_reg, wb_value, next_address, retired_count, zero pad
    output logic [rie_pkg::OUT_W-1:0]    m_tdata,
    // status
    output logic                         m_tuser
);
    import rie_pkg::*;

    in_item_t          in_item;
    logic              accept;
    logic              out_free;
    logic              commit;

    logic              ex_valid_reg;
    in_item_t          ex_item_reg;
    logic              fwd_rs_en_reg;
    logic              fwd_rs_en_next;
    logic [WORD_W-1:0] fwd_rs_val_reg;
    logic [WORD_W-1:0] fwd_rs_val_next;
    logic              fwd_rt_en_reg;
    logic              fwd_rt_en_next;
    logic [WORD_W-1:0] fwd_rt_val_reg;
    logic [WORD_W-1:0] fwd_rt_val_next;

    logic [WORD_W-1:0] hi_reg;
    logic [WORD_W-1:0] lo_reg;
    logic [WORD_W-1:0] pc_reg;
    logic [WORD_W-1:0] pc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic              status_reg;

    logic [WORD_W-1:0] rf_rs;
    logic [WORD_W-1:0] rf_rt;
    logic [WORD_W-1:0] op_rs;
    logic [WORD_W-1:0] op_rt;
    logic [WORD_W-1:0] pc_base;
    logic [CNT_W-1:0]  cnt_base;
    alu_res_t          alu_res;
    rf_wr_t            rf_wr;

    assign in_item  = in_item_t'(s_tdata);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !ex_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign commit   = ex_valid_reg && out_free;

    // register file writes of the word leaving the execute stage
    always_comb
    begin
        rf_wr.wr_en  = commit && alu_res.wr;
        rf_wr.wr_reg = alu_res.dst;
        rf_wr.wr_val = alu_res.val;
        rf_wr.ld_en  = commit && ex_item_reg.load_valid
                       && (ex_item_reg.load_reg != REG_ZERO)
                       && !(alu_res.wr && (alu_res.dst == ex_item_reg.load_reg));
        rf_wr.ld_reg = ex_item_reg.load_reg;
        rf_wr.ld_val = ex_item_reg.load_value;
    end

    rie_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rs_addr (in_item.src_index),
        .rt_addr (in_item.tgt_index),
        .rs_data (rf_rs),
        .rt_data (rf_rt),
        .wr      (rf_wr)
    );

    // forward writes that land on the same edge as the operand read
    always_comb
    begin
        fwd_rs_en_next  = 1'b1;
        fwd_rs_val_next = '0;
        if (rf_wr.wr_en && (rf_wr.wr_reg == in_item.src_index))
            fwd_rs_val_next = rf_wr.wr_val;
        else if (rf_wr.ld_en && (rf_wr.ld_reg == in_item.src_index))
            fwd_rs_val_next = rf_wr.ld_val;
        else
            fwd_rs_en_next = 1'b0;

        fwd_rt_en_next  = 1'b1;
        fwd_rt_val_next = '0;
        if (rf_wr.wr_en && (rf_wr.wr_reg == in_item.tgt_index))
            fwd_rt_val_next = rf_wr.wr_val;
        else if (rf_wr.ld_en && (rf_wr.ld_reg == in_item.tgt_index))
            fwd_rt_val_next = rf_wr.ld_val;
        else
            fwd_rt_en_next = 1'b0;
    end

    // execute stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_item_reg    <= in_item;
            fwd_rs_val_reg <= fwd_rs_val_next;
            fwd_rt_val_reg <= fwd_rt_val_next;
        end
    end

    assign op_rs = fwd_rs_en_reg ? fwd_rs_val_reg : rf_rs;
    assign op_rt = fwd_rt_en_reg ? fwd_rt_val_reg : rf_rt;

    rie_alu u_alu (
        .func         (ex_item_reg.func),
        .rs           (op_rs),
        .rt           (op_rt),
        .shift_amount (ex_item_reg.shift_amount),
        .imm_value    (ex_item_reg.imm_value),
        .dst_index    (ex_item_reg.dst_index),
        .tgt_index    (ex_item_reg.tgt_index),
        .hi           (hi_reg),
        .lo           (lo_reg),
        .res          (alu_res)
    );

    // program counter and retired count
    always_comb
    begin
        pc_base  = ex_item_reg.block_start ? ex_item_reg.entry_address : pc_reg;
        cnt_base = ex_item_reg.block_start ? '0 : cnt_reg;
        pc_next  = pc_base;
        cnt_next = cnt_base;
        if (alu_res.ok)
        begin
            pc_next = pc_base + PC_STEP;
            if (cnt_base != CNT_MAX)
                cnt_next = cnt_base + 1'b1;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            fwd_rs_en_reg <= 1'b0;
            fwd_rt_en_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            pc_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (s_tready)
                ex_valid_reg <= s_tvalid;
            if (accept)
            begin
                fwd_rs_en_reg <= fwd_rs_en_next;
                fwd_rt_en_reg <= fwd_rt_en_next;
            end
            if (out_free)
                out_valid_reg <= ex_valid_reg;
            if (commit)
            begin
                pc_reg  <= pc_next;
                cnt_reg <= cnt_next;
                if (alu_res.hi_we)
                    hi_reg <= op_rs;
                if (alu_res.lo_we)
                    lo_reg <= op_rs;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg                 <= !alu_res.ok;
            out_item_reg.pad           <= '0;
            out_item_reg.wb_valid      <= alu_res.wr;
            out_item_reg.wb_reg        <= alu_res.dst;
            out_item_reg.wb_value      <= alu_res.val;
            out_item_reg.next_address  <= pc_next;
            out_item_reg.retired_count <= cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_item_reg);
    assign m_tuser  = status_reg;

`ifndef SYNTHESIS
    // an unsupported operation never reports a register write
    a_status_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !out_item_reg.wb_valid)
        else $error("unsupported operation reported a register write");

    // register zero is never reported as written
    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_item_reg.wb_valid) |-> (out_item_reg.wb_reg != REG_ZERO))
        else $error("write to register zero reported");

    // no write means register and value are both zero
    a_idle_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_item_reg.wb_valid)
        |-> (out_item_reg.wb_reg == REG_ZERO && out_item_reg.wb_value == '0))
        else $error("write fields not cleared without a write");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    // the bank write ports never collide on one register
    a_bank_no_alias: assert property (@(posedge clk) disable iff (!rst_n)
        (rf_wr.ld_en && rf_wr.wr_en) |-> (rf_wr.ld_reg != rf_wr.wr_reg))
        else $error("load and result written to the same register");
`endif

endmodule
